// File: design/rdbd_pkg.sv
// ----------------------------------------------------------------------------
// rdbd_pkg
// Shared types and constants of the raw delta block decoder
// ----------------------------------------------------------------------------
package rdbd_pkg;

  localparam int unsigned PixW     = 11;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned DeltaW   = 7;
  localparam int unsigned ShW      = 3;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned NumLanes = 16;
  localparam int unsigned NumDelta = 14;
  localparam int unsigned DeltaPos = 30;

  localparam logic [PixW-1:0] PixMax = 11'h7FF;

  // per-block header fields seen by every lane
  typedef struct packed {
    logic [PixW-1:0] max_val;
    logic [PixW-1:0] min_val;
    logic [IdxW-1:0] max_idx;
    logic [IdxW-1:0] min_idx;
    logic [ShW-1:0]  shift;
    logic            bad;
  } hdr_t;

  // deltas in order; the entries past the block read as zero
  typedef logic [NumLanes-1:0][DeltaW-1:0] delta_arr_t;

  // pixels of one block in slot order
  typedef logic [NumLanes-1:0][PixW-1:0] pix_arr_t;

endpackage

// File: design/rdbd_if.sv
// ----------------------------------------------------------------------------
// rdbd_block_if / rdbd_pixel_if
// Valid/ready channels for compressed blocks and decoded pixels
// ----------------------------------------------------------------------------
interface rdbd_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;

  modport source (output valid, output block_low, output block_high, input ready);
  modport sink (input valid, input block_low, input block_high, output ready);
endinterface

interface rdbd_pixel_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_value;
  logic [4:0]  group_slot;
  logic        malformed;
  logic        last;

  modport source (output valid, output pixel_value, output group_slot,
                  output malformed, output last, input ready);
  modport sink (input valid, input pixel_value, input group_slot,
                input malformed, input last, output ready);
endinterface

// File: design/rdbd_lane.sv
// ----------------------------------------------------------------------------
// rdbd_lane
// Decodes the pixel of one slot of a block
// ----------------------------------------------------------------------------
module rdbd_lane
  import rdbd_pkg::*;
(
  input  logic [IdxW-1:0] lane_idx_i,
  input  hdr_t            hdr_i,
  input  delta_arr_t      deltas_i,
  output logic [PixW-1:0] pix_o
);

  logic            before_max;
  logic            before_min;
  logic [IdxW-1:0] delta_sel;
  logic [PixW-1:0] shifted;
  logic [PixW:0]   sum;

  // count of delta slots ahead of this one
  assign before_max = (hdr_i.max_idx < lane_idx_i);
  assign before_min = (hdr_i.min_idx < lane_idx_i) && !hdr_i.bad;
  assign delta_sel  = lane_idx_i - IdxW'(before_max) - IdxW'(before_min);

  // scaled delta over min, saturated
  assign shifted = {{(PixW-DeltaW){1'b0}}, deltas_i[delta_sel]} << hdr_i.shift;
  assign sum     = {1'b0, shifted} + {1'b0, hdr_i.min_val};

  always_comb begin
    priority if (lane_idx_i == hdr_i.max_idx) begin
      pix_o = hdr_i.max_val;
    end else if (lane_idx_i == hdr_i.min_idx) begin
      pix_o = hdr_i.min_val;
    end else if (sum[PixW]) begin
      pix_o = PixMax;
    end else begin
      pix_o = sum[PixW-1:0];
    end
  end

endmodule

// File: design/rdbd_serializer.sv
// ----------------------------------------------------------------------------
// rdbd_serializer
// Merges the lane results into a pixel stream, one transfer per pixel
// ----------------------------------------------------------------------------
module rdbd_serializer
  import rdbd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_valid_i,
  output logic          load_ready_o,
  input  pix_arr_t      pix_i,
  input  logic          bad_i,
  rdbd_pixel_if.source  out_o
);

  pix_arr_t        pix_q, pix_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            bad_q, bad_d;
  logic            odd_q, odd_d;
  logic            fire;
  logic            done;
  logic            load;

  assign fire         = busy_q && out_o.ready;
  assign done         = fire && (cnt_q == IdxW'(NumLanes - 1));
  assign load_ready_o = !busy_q || done;
  assign load         = load_valid_i && load_ready_o;

  // next block loads as the last pixel of the current one goes out
  always_comb begin
    pix_d  = pix_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    bad_d  = bad_q;
    odd_d  = odd_q;
    if (fire) begin
      pix_d = {{PixW{1'b0}}, pix_q[NumLanes-1:1]};
      cnt_d = cnt_q + 1'b1;
    end
    if (done) begin
      busy_d = 1'b0;
      odd_d  = !odd_q;
    end
    if (load) begin
      pix_d  = pix_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      bad_d  = bad_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      odd_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      odd_q  <= odd_d;
    end
  end

  // pixel payload, no reset
  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    bad_q <= bad_d;
  end

  assign out_o.valid       = busy_q;
  assign out_o.pixel_value = pix_q[0];
  assign out_o.group_slot  = {cnt_q, odd_q};
  assign out_o.malformed   = bad_q;
  assign out_o.last        = (cnt_q == IdxW'(NumLanes - 1));

endmodule

// File: design/raw_delta_block_decoder_top.sv
// ----------------------------------------------------------------------------
// raw_delta_block_decoder_top
// Decodes 128-bit compressed blocks into sixteen 11-bit pixels each
// ----------------------------------------------------------------------------
// channel   dir  payload                                        handshake
// in_i      in   block_low[63:0], block_high[63:0]              valid/ready
// out_o     out  pixel_value[10:0], group_slot[4:0],            valid/ready
//                malformed, last
//
// the pixel port moves one pixel per transfer, sixteen transfers per block
// sixteen lanes decode a whole block combinationally from the input register
// the input register takes the next block while the current one drains
// reset clears the valid flags, the slot count and the even/odd toggle
// output stalls hold the pixel stream and, once both stages are full, the input
// ----------------------------------------------------------------------------
module raw_delta_block_decoder_top
  import rdbd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  rdbd_block_if.sink   in_i,
  rdbd_pixel_if.source out_o
);

  logic [127:0]    blk_q;
  logic            blk_vld_q;
  logic            load_ready;
  hdr_t            hdr;
  delta_arr_t      deltas;
  pix_arr_t        pix;
  logic signed [PixW:0] span;
  logic [ShW-1:0]  shift;

  // input register
  assign in_i.ready = !blk_vld_q || load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      blk_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      blk_q <= {in_i.block_high, in_i.block_low};
    end
  end

  // header fields and shift from the span
  assign hdr.max_val = blk_q[10:0];
  assign hdr.min_val = blk_q[21:11];
  assign hdr.max_idx = blk_q[25:22];
  assign hdr.min_idx = blk_q[29:26];
  assign hdr.bad     = (hdr.max_idx == hdr.min_idx);
  assign hdr.shift   = shift;
  assign span        = $signed({1'b0, hdr.max_val}) - $signed({1'b0, hdr.min_val});

  always_comb begin
    priority if (span < 12'sd128) begin
      shift = 3'd0;
    end else if (span < 12'sd256) begin
      shift = 3'd1;
    end else if (span < 12'sd512) begin
      shift = 3'd2;
    end else if (span < 12'sd1024) begin
      shift = 3'd3;
    end else begin
      shift = 3'd4;
    end
  end

  // delta fields, zero past the block
  always_comb begin
    deltas = '0;
    for (int k = 0; k < NumDelta; k++) begin
      deltas[k] = blk_q[DeltaPos + DeltaW*k +: DeltaW];
    end
  end

  // one lane per slot
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    rdbd_lane u_lane (
      .lane_idx_i (IdxW'(g)),
      .hdr_i      (hdr),
      .deltas_i   (deltas),
      .pix_o      (pix[g])
    );
  end

  rdbd_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (blk_vld_q),
    .load_ready_o (load_ready),
    .pix_i        (pix),
    .bad_i        (hdr.bad),
    .out_o        (out_o)
  );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Block-level test of the raw delta block decoder: compressed blocks go in,
// each is decoded by a local predictor into sixteen expected pixels, and every
// pixel transfer is checked in order against them, field by field
// ----------------------------------------------------------------------------
module tb_top;
  import rdbd_pkg::*;

  localparam int unsigned ShiftBase   = 128;
  localparam int unsigned MaxShift    = 4;
  localparam int unsigned IdlePct     = 31;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 48;

  // one expected pixel as the output port carries it
  typedef struct packed {
    logic [PixW-1:0]  value;
    logic [SlotW-1:0] slot;
    logic             bad;
    logic             last;
  } pixel_rec_t;

  logic clk_i;
  logic rst_ni;

  rdbd_block_if blk_if ();
  rdbd_pixel_if pix_if ();

  raw_delta_block_decoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (blk_if.sink),
    .out_o  (pix_if.source)
  );

  pixel_rec_t  pending_pixels[$];
  logic        odd_blk       = 1'b0;
  logic        blk_gaps_on   = 1'b1;
  logic        pix_stalls_on = 1'b1;
  int unsigned err_count     = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // decode one block into its sixteen pixels and queue them
  function automatic void decode_block(input logic [127:0] blk);
    logic [PixW-1:0]   mx;
    logic [PixW-1:0]   mn;
    logic [IdxW-1:0]   ix_max;
    logic [IdxW-1:0]   ix_min;
    logic [DeltaW-1:0] d;
    int                span;
    int                sh;
    int                nxt;
    int                sum;
    int                i;
    pixel_rec_t        rec;
    mx     = blk[10:0];
    mn     = blk[21:11];
    ix_max = blk[25:22];
    ix_min = blk[29:26];
    span   = int'(mx) - int'(mn);
    sh     = 0;
    while (sh < MaxShift && int'(ShiftBase << sh) <= span) sh++;
    nxt = 0;
    for (i = 0; i < NumLanes; i++) begin
      if (i == ix_max) begin
        rec.value = mx;
      end else if (i == ix_min) begin
        rec.value = mn;
      end else begin
        // a delta past bit 127 reads as zero
        d   = DeltaW'(blk >> (DeltaPos + DeltaW * nxt));
        nxt++;
        sum = (int'(d) << sh) + int'(mn);
        rec.value = (sum > int'(PixMax)) ? PixMax : PixW'(sum);
      end
      rec.slot = {i[3:0], odd_blk};
      rec.bad  = (ix_max == ix_min);
      rec.last = (i == NumLanes - 1);
      pending_pixels.push_back(rec);
    end
    odd_blk = ~odd_blk;
  endfunction

  function automatic logic [127:0] make_block(input logic [PixW-1:0] mx,
                                              input logic [PixW-1:0] mn,
                                              input logic [IdxW-1:0] ix_max,
                                              input logic [IdxW-1:0] ix_min,
                                              input logic [97:0]     deltas);
    return {deltas, ix_min, ix_max, mn, mx};
  endfunction

  // random block, biased toward shift steps, inverted ranges and clamping
  function automatic logic [127:0] rand_block();
    logic [127:0] blk;
    int unsigned  bnd;
    int unsigned  sp;
    int unsigned  mn;
    blk = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 4))
      0, 1: ;
      2: begin
        bnd = ShiftBase << $urandom_range(0, MaxShift - 1);
        sp  = bnd - 1 + $urandom_range(0, 1);
        mn  = $urandom_range(0, PixMax - sp);
        blk[21:11] = PixW'(mn);
        blk[10:0]  = PixW'(mn + sp);
      end
      3: begin
        mn = $urandom_range(1, PixMax);
        blk[21:11] = PixW'(mn);
        blk[10:0]  = PixW'($urandom_range(0, mn - 1));
      end
      default: begin
        blk[21:11] = PixW'($urandom_range(PixMax - 300, PixMax));
      end
    endcase
    // equal indices a bit more often than chance
    if ($urandom_range(0, 7) == 0) blk[29:26] = blk[25:22];
    return blk;
  endfunction

  // drive one block and wait for its transfer
  task automatic send_block(input logic [127:0] blk);
    while (blk_gaps_on && $urandom_range(0, 99) < IdlePct) begin
      blk_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    blk_if.valid      <= 1'b1;
    blk_if.block_low  <= blk[63:0];
    blk_if.block_high <= blk[127:64];
    do begin
      @(posedge clk_i);
    end while (!blk_if.ready);
    decode_block(blk);
  endtask

  task automatic wait_drained();
    blk_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // field extremes, each shift step, index corners, equal indices, clamping
  task automatic test_directed();
    logic [97:0] ones_d;
    logic [97:0] zero_d;
    ones_d = '1;
    zero_d = '0;
    send_block('0);
    send_block('1);
    send_block(make_block(11'd2047, 11'd0, 4'd15, 4'd0, ones_d));
    send_block(make_block(11'd0, 11'd2047, 4'd0, 4'd15, ones_d));
    send_block(make_block(11'd127, 11'd0, 4'd3, 4'd9, ones_d));
    send_block(make_block(11'd128, 11'd0, 4'd9, 4'd3, ones_d));
    send_block(make_block(11'd1278, 11'd1023, 4'd1, 4'd2, ones_d));
    send_block(make_block(11'd1279, 11'd1023, 4'd2, 4'd1, ones_d));
    send_block(make_block(11'd511, 11'd0, 4'd14, 4'd15, ones_d));
    send_block(make_block(11'd512, 11'd0, 4'd15, 4'd14, ones_d));
    send_block(make_block(11'd2046, 11'd1023, 4'd5, 4'd6, ones_d));
    send_block(make_block(11'd2047, 11'd1023, 4'd6, 4'd5, ones_d));
    send_block(make_block(11'd2047, 11'd2047, 4'd4, 4'd8, ones_d));
    send_block(make_block(11'd2047, 11'd1900, 4'd0, 4'd1, ones_d));
    send_block(make_block(11'd5, 11'd100, 4'd7, 4'd10,
                          98'({$urandom, $urandom, $urandom, $urandom})));
    send_block(make_block(11'd0, 11'd2047, 4'd0, 4'd0, ones_d));
    send_block(make_block(11'd300, 11'd10, 4'd7, 4'd7, ones_d));
    send_block(make_block(11'd2047, 11'd0, 4'd15, 4'd15, ones_d));
    send_block(make_block(11'd1000, 11'd1000, 4'd0, 4'd0, zero_d));
    send_block(make_block(11'd0, 11'd0, 4'd15, 4'd0, {49{2'b10}}));
    send_block(make_block(11'd1024, 11'd0, 4'd8, 4'd11, {49{2'b01}}));
    send_block(make_block(11'h555, 11'h2AA, 4'd10, 4'd5, {49{2'b10}}));
  endtask

  task automatic test_random_traffic(input int unsigned n);
    repeat (n) send_block(rand_block());
  endtask

  // long stretch with no gaps and no stalls
  task automatic test_back_to_back(input int unsigned n);
    blk_gaps_on   = 1'b0;
    pix_stalls_on = 1'b0;
    repeat (n) send_block(rand_block());
    blk_gaps_on   = 1'b1;
    pix_stalls_on = 1'b1;
  endtask

  // sender holds off until the pixel stream has fully drained
  task automatic test_drain_pause(input int unsigned n);
    repeat (n) send_block(rand_block());
    wait_drained();
    repeat (n) send_block(rand_block());
  endtask

  task automatic cmp_field(input string name, input logic [PixW-1:0] want,
                           input logic [PixW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // pixel checker and output stall driver
  initial begin
    pixel_rec_t want;
    pix_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pix_if.valid && pix_if.ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: pixel transfer with nothing expected: value %0d slot %0d",
                   $time, pix_if.pixel_value, pix_if.group_slot);
          err_count++;
        end else begin
          want = pending_pixels.pop_front();
          cmp_field("pixel_value", want.value, pix_if.pixel_value);
          cmp_field("group_slot", PixW'(want.slot), PixW'(pix_if.group_slot));
          cmp_field("malformed", PixW'(want.bad), PixW'(pix_if.malformed));
          cmp_field("last", PixW'(want.last), PixW'(pix_if.last));
        end
      end
      pix_if.ready <= !(pix_stalls_on && $urandom_range(0, 99) < IdlePct);
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((blk_if.valid && blk_if.ready) || (pix_if.valid && pix_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog: no transfer for %0d cycles", $time, StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni            <= 1'b0;
    blk_if.valid      <= 1'b0;
    blk_if.block_low  <= '0;
    blk_if.block_high <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(220);
    test_back_to_back(120);
    test_drain_pause(40);
    test_random_traffic(40);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rdbd_pkg.sv
design/rdbd_if.sv
design/rdbd_lane.sv
design/rdbd_serializer.sv
design/raw_delta_block_decoder_top.sv
verif/tb_top.sv
